// ----- sv/ste_pkg.sv -----
// Shared types and codes of the software timer engine.
`timescale 1ns / 1ps

package ste_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ALLOC  = 3'd1;
  localparam logic [2:0] CMD_FREE   = 3'd2;
  localparam logic [2:0] CMD_ARM    = 3'd3;
  localparam logic [2:0] CMD_DISARM = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_PERIODIC = 2'd1;
  localparam logic [1:0] KIND_ONESHOT  = 2'd2;
  localparam logic [1:0] KIND_ALLOC    = 2'd3;

  // register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWNER_FIRST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_USED = 3'd6;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  slot;
    logic [15:0] timeout;
    logic [1:0]  owner;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] dest_task;
    logic [1:0] timer_slot;
    logic       alloc_failed;
    logic       last_result;
  } out_item_t;

  // register writes seen by one periodic cell
  typedef struct packed {
    logic        wr_period;
    logic        wr_owner;
    logic [15:0] period;
    logic [1:0]  owner;
  } pcfg_t;

  // command strobes seen by one one-shot cell
  typedef struct packed {
    logic        alloc;
    logic        release_slot;
    logic        arm;
    logic        disarm;
    logic [15:0] timeout;
    logic [1:0]  owner;
  } os_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ----- sv/software_timer_engine_core.sv -----
// Top level of the software timer engine: cell chain, command decode, result register.
//
// Usage: drive in_data and raise start; the command transfers at an edge where
// busy is low. Results leave through out_data, each valid for one cycle while
// out_valid is high; the receiver must take them, there is no stall.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register at an
// edge; write only while busy is low and no tick result is outstanding.
// Allocate, free, arm and disarm complete at once: the single result shows in
// the cycle after the transfer and busy stays low, so these commands can
// follow each other every cycle.
// A tick walks a token down a row of PERIODIC_TIMERS + ONESHOT_TIMERS timer
// cells, one cell per cycle. Each expiry is held in a pending register so the
// final one can be marked; busy stays high until the token has left the last
// cell, and the last result is registered after that and shows as busy
// falls; the next command is taken from then on. The length of the cell walk
// sets when busy falls and the last result appears.
// Reset (rst_n low, synchronous) loads periods and periodic counts with 1,
// clears owners, one-shot timers and the periodic count in use; no clearing
// pass follows, commands are taken right after reset.
`timescale 1ns / 1ps

module software_timer_engine_core #(
  parameter int PERIODIC_TIMERS = 3,
  parameter int ONESHOT_TIMERS  = 4,
  parameter int TASK_COUNT      = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ste_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output ste_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [ste_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ste_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CELLS  = PERIODIC_TIMERS + ONESHOT_TIMERS;
  localparam int SLOT_W = (ONESHOT_TIMERS > 1) ? $clog2(ONESHOT_TIMERS) : 1;

  function automatic logic [1:0] clamp_task(input logic [1:0] v);
    logic [1:0] r;
    r = v;
    if (int'(v) >= TASK_COUNT) begin
      r = 2'(TASK_COUNT - 1);
    end
    return r;
  endfunction

  ste_pkg::state_t    state_r, state_nxt;
  logic               tok0_r, tok0_nxt;
  logic [1:0]         used_r, used_nxt;
  ste_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  ste_pkg::out_item_t pend_r, pend_nxt;
  logic               pend_valid_r, pend_valid_nxt;

  logic tok [0:CELLS];
  logic p_fire  [PERIODIC_TIMERS];
  logic [1:0] p_owner [PERIODIC_TIMERS];
  logic o_fire  [ONESHOT_TIMERS];
  logic [1:0] o_owner [ONESHOT_TIMERS];
  logic o_busy  [ONESHOT_TIMERS];

  logic               in_acc;
  logic               scan_done;
  logic               alloc_found;
  logic [SLOT_W-1:0]  alloc_idx;
  logic               evt_valid;
  ste_pkg::out_item_t evt;

  assign in_acc    = start && !busy;
  assign scan_done = tok[CELLS];
  assign tok[0]    = tok0_r;

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < PERIODIC_TIMERS; i++) begin : g_pcell
    ste_pkg::pcfg_t pcfg;
    assign pcfg.wr_period = cfg_we &&
                            (cfg_index == ste_pkg::REG_PERIOD_FIRST + 3'(i));
    assign pcfg.wr_owner  = cfg_we &&
                            (cfg_index == ste_pkg::REG_OWNER_FIRST + 3'(i));
    assign pcfg.period    = cfg_wdata;
    assign pcfg.owner     = clamp_task(cfg_wdata[1:0]);

    ste_pcell u_pcell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[i]),
      .en      (int'(used_r) > i),
      .cfg     (pcfg),
      .tok_out (tok[i+1]),
      .fire    (p_fire[i]),
      .owner   (p_owner[i])
    );
  end

  for (genvar j = 0; j < ONESHOT_TIMERS; j++) begin : g_ocell
    ste_pkg::os_cmd_t ocmd;
    logic hit;
    assign hit = in_acc && (int'(in_data.slot) == j);
    assign ocmd.alloc = in_acc && (in_data.cmd == ste_pkg::CMD_ALLOC) &&
                        alloc_found && (int'(alloc_idx) == j);
    assign ocmd.release_slot = hit && (in_data.cmd == ste_pkg::CMD_FREE);
    assign ocmd.arm     = hit && (in_data.cmd == ste_pkg::CMD_ARM);
    assign ocmd.disarm  = hit && (in_data.cmd == ste_pkg::CMD_DISARM);
    assign ocmd.timeout = in_data.timeout;
    assign ocmd.owner   = clamp_task(in_data.owner);

    ste_ocell u_ocell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[PERIODIC_TIMERS + j]),
      .cmd     (ocmd),
      .tok_out (tok[PERIODIC_TIMERS + j + 1]),
      .fire    (o_fire[j]),
      .owner   (o_owner[j]),
      .busy    (o_busy[j])
    );
  end

  // lowest free one-shot slot
  always_comb begin
    alloc_found = 1'b0;
    alloc_idx   = '0;
    for (int j = ONESHOT_TIMERS - 1; j >= 0; j--) begin
      if (!o_busy[j]) begin
        alloc_found = 1'b1;
        alloc_idx   = SLOT_W'(j);
      end
    end
  end

  // the token is one-hot, so at most one cell fires per cycle
  always_comb begin
    evt_valid = 1'b0;
    evt       = '0;
    for (int i = 0; i < PERIODIC_TIMERS; i++) begin
      if (p_fire[i]) begin
        evt_valid      = 1'b1;
        evt.kind       = ste_pkg::KIND_PERIODIC;
        evt.dest_task  = p_owner[i];
        evt.timer_slot = 2'(i);
      end
    end
    for (int j = 0; j < ONESHOT_TIMERS; j++) begin
      if (o_fire[j]) begin
        evt_valid      = 1'b1;
        evt.kind       = ste_pkg::KIND_ONESHOT;
        evt.dest_task  = o_owner[j];
        evt.timer_slot = 2'(j);
      end
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ste_pkg::ST_IDLE: begin
        if (in_acc && (in_data.cmd == ste_pkg::CMD_TICK)) begin
          state_nxt = ste_pkg::ST_SCAN;
        end
      end
      ste_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ste_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ste_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r == ste_pkg::ST_SCAN);
  end

  // ---------------- results ----------------
  always_comb begin
    tok0_nxt       = in_acc && (in_data.cmd == ste_pkg::CMD_TICK);
    used_nxt       = used_r;
    out_nxt        = out_r;
    out_valid_nxt  = 1'b0;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;

    if (cfg_we && (cfg_index == ste_pkg::REG_PERIODIC_USED)) begin
      used_nxt = cfg_wdata[1:0];
    end

    if (in_acc && (in_data.cmd != ste_pkg::CMD_TICK)) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      out_nxt.last_result = 1'b1;
      unique case (in_data.cmd)
        ste_pkg::CMD_ALLOC: begin
          out_nxt.kind         = ste_pkg::KIND_ALLOC;
          out_nxt.timer_slot   = alloc_found ? 2'(alloc_idx) : 2'd0;
          out_nxt.alloc_failed = !alloc_found;
        end
        default: out_nxt.kind = ste_pkg::KIND_NONE;
      endcase
    end

    if (busy && evt_valid) begin
      // a newer expiry releases the held one as a non-final transfer
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_nxt.last_result = 1'b0;
      end
      pend_nxt       = evt;
      pend_valid_nxt = 1'b1;
    end

    if (busy && scan_done) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_valid_r ? pend_r : '0;
      out_nxt.last_result = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ste_pkg::ST_IDLE;
      tok0_r       <= 1'b0;
      used_r       <= 2'd0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tok0_r       <= tok0_nxt;
      used_r       <= used_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/ste_pcell.sv -----
// Periodic timer cell: counter, period and owner; passes the scan token on.
`timescale 1ns / 1ps

module ste_pcell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_in,
  input  logic          en,
  input  ste_pkg::pcfg_t cfg,
  output logic          tok_out,
  output logic          fire,
  output logic [1:0]    owner
);

  logic [15:0] period_r, period_nxt;
  logic [15:0] count_r, count_nxt;
  logic [1:0]  owner_r, owner_nxt;
  logic        tok_r;

  assign fire    = tok_in && en && (count_r == 16'd1);
  assign owner   = owner_r;
  assign tok_out = tok_r;

  always_comb begin
    period_nxt = period_r;
    count_nxt  = count_r;
    owner_nxt  = owner_r;
    if (cfg.wr_period) begin
      period_nxt = cfg.period;
      count_nxt  = cfg.period;
    end else if (tok_in && en) begin
      // reload on expiry; a zero period wraps through 65536 ticks
      count_nxt = fire ? period_r : count_r - 16'd1;
    end
    if (cfg.wr_owner) begin
      owner_nxt = cfg.owner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd1;
      count_r  <= 16'd1;
      owner_r  <= 2'd0;
      tok_r    <= 1'b0;
    end else begin
      period_r <= period_nxt;
      count_r  <= count_nxt;
      owner_r  <= owner_nxt;
      tok_r    <= tok_in;
    end
  end

endmodule

// ----- sv/ste_ocell.sv -----
// One-shot timer cell: counter, armed and busy flags, owner; passes the token on.
`timescale 1ns / 1ps

module ste_ocell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_in,
  input  ste_pkg::os_cmd_t cmd,
  output logic             tok_out,
  output logic             fire,
  output logic [1:0]       owner,
  output logic             busy
);

  logic [15:0] count_r, count_nxt;
  logic        armed_r, armed_nxt;
  logic        busy_r, busy_nxt;
  logic [1:0]  owner_r, owner_nxt;
  logic        tok_r;

  assign fire    = tok_in && armed_r && (count_r == 16'd1);
  assign owner   = owner_r;
  assign busy    = busy_r;
  assign tok_out = tok_r;

  always_comb begin
    count_nxt = count_r;
    armed_nxt = armed_r;
    busy_nxt  = busy_r;
    owner_nxt = owner_r;
    if (cmd.alloc) begin
      busy_nxt  = 1'b1;
      armed_nxt = 1'b0;
      owner_nxt = cmd.owner;
    end else if (cmd.release_slot) begin
      busy_nxt  = 1'b0;
      armed_nxt = 1'b0;
    end else if (cmd.arm) begin
      count_nxt = cmd.timeout;
      armed_nxt = 1'b1;
    end else if (cmd.disarm) begin
      armed_nxt = 1'b0;
    end else if (tok_in && armed_r) begin
      count_nxt = count_r - 16'd1;
      if (fire) begin
        armed_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 16'd0;
      armed_r <= 1'b0;
      busy_r  <= 1'b0;
      owner_r <= 2'd0;
      tok_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      armed_r <= armed_nxt;
      busy_r  <= busy_nxt;
      owner_r <= owner_nxt;
      tok_r   <= tok_in;
    end
  end

endmodule

// ----- sv/ste_checker.sv -----
// Port-level checks for the software timer engine, bound to the top level.
`timescale 1ns / 1ps

module ste_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input ste_pkg::in_item_t  in_data,
  input logic               out_valid,
  input ste_pkg::out_item_t out_data
);

  // a command other than tick answers in the next cycle with one final result
  a_cmd_reply: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd != ste_pkg::CMD_TICK)
      |=> out_valid && out_data.last_result)
    else $error("command result missing after transfer");

  // a tick occupies the block
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd == ste_pkg::CMD_TICK) |=> busy && !out_valid)
    else $error("tick did not start a scan");

  // non-final results only come out of a running scan
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> busy &&
      (out_data.kind == ste_pkg::KIND_PERIODIC || out_data.kind == ste_pkg::KIND_ONESHOT))
    else $error("non-final result outside a tick");

  // the end of a scan always delivers the final result
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_data.last_result)
    else $error("scan ended without final result");

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alloc_failed |->
      (out_data.kind == ste_pkg::KIND_ALLOC) && (out_data.timer_slot == 2'd0))
    else $error("bad failed allocation reply");

endmodule

bind software_timer_engine_core ste_checker u_ste_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
